// ===== hw/rtl/ssf_pkg.sv =====
`timescale 1ns / 1ps

package ssf_pkg;

    localparam int MAX_NODES = 32;
    localparam int ROW_WIDTH = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = $clog2(MAX_NODES + 1);

    typedef struct packed {
        logic [ROW_WIDTH-1:0] row_bits;
        logic                 last_row;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [COUNT_W-1:0] subtour_length;
        logic               full_tour;
        logic               last;
    } out_item_t;

    // A count of zero behaves as one node; anything above the table size is clipped.
    function automatic logic [COUNT_W-1:0] effective_nodes(input logic [COUNT_W-1:0] nc);
        logic [COUNT_W-1:0] n;
        n = nc;
        if (nc == '0)
        begin
            n = COUNT_W'(1);
        end
        else if (nc > COUNT_W'(MAX_NODES))
        begin
            n = COUNT_W'(MAX_NODES);
        end
        return n;
    endfunction

    function automatic logic [ROW_WIDTH-1:0] node_mask(input logic [COUNT_W-1:0] n);
        logic [ROW_WIDTH-1:0] m;
        if (n >= COUNT_W'(ROW_WIDTH))
        begin
            m = '1;
        end
        else
        begin
            m = (ROW_WIDTH'(1) << n) - ROW_WIDTH'(1);
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/ssf_lowest_set.sv =====
`timescale 1ns / 1ps

module ssf_lowest_set
    import ssf_pkg::*;
(
    input  logic [ROW_WIDTH-1:0] word,
    output logic [NODE_W-1:0]    index,
    output logic                 found
);

    // Scanning from the top down leaves the lowest set bit as the final pick.
    always_comb
    begin
        index = '0;
        for (int i = ROW_WIDTH - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                index = NODE_W'(i);
            end
        end
        found = |word;
    end

endmodule

// ===== hw/rtl/shortest_subtour_finder.sv =====
`timescale 1ns / 1ps

// Shortest subtour finder. Rows of a thresholded 0/1 edge matrix are loaded one per cycle,
// row 0 first; the row flagged last_row starts the search, and in_stall stays high until
// the whole result has been delivered. The search walks every cycle of the selected edges,
// starting each at the lowest unvisited node and stepping to the lowest unvisited neighbor,
// and passes through a setup state, one step per node visited, one more step to close each
// cycle found and a final check, all through a single lowest-set-bit encoder and a registered
// read of the edge memory. The first shortest cycle is then sent out in walk order, one
// transfer per node. Every transfer carries the cycle length and a flag that is set when
// that cycle covers all nodes in use.
// node_count may be written only while the block is idle.

module shortest_subtour_finder
    import ssf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_NEW_WALK,
        ST_STEP,
        ST_EMIT_READ,
        ST_EMIT_HOLD
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   node_count_reg;
    logic [COUNT_W-1:0]   row_cnt_reg;
    logic [ROW_WIDTH-1:0] visited_reg;
    logic [COUNT_W-1:0]   start_reg;
    logic [COUNT_W-1:0]   len_reg;
    logic [NODE_W-1:0]    best_start_reg;
    logic [COUNT_W-1:0]   best_len_reg;
    logic [COUNT_W-1:0]   emit_cnt_reg;
    logic                 out_valid_reg;
    logic                 out_full_reg;
    logic                 out_last_reg;

    logic [ROW_WIDTH-1:0] edge_mem [MAX_NODES];
    logic [NODE_W-1:0]    walk_mem [MAX_NODES];
    logic [ROW_WIDTH-1:0] edge_rd_reg;
    logic [NODE_W-1:0]    walk_rd_reg;

    logic [COUNT_W-1:0]   n_eff;
    logic [ROW_WIDTH-1:0] nmask;
    logic [ROW_WIDTH-1:0] unvisited;
    logic [ROW_WIDTH-1:0] cand;
    logic [ROW_WIDTH-1:0] enc_word;
    logic [NODE_W-1:0]    enc_index;
    logic                 enc_found;
    logic                 in_xfer;
    logic                 row_we;
    logic                 walk_end;
    logic                 search_done;
    logic                 walk_we;
    logic [NODE_W-1:0]    walk_waddr;
    logic [COUNT_W-1:0]   walk_pos;
    logic [NODE_W-1:0]    walk_raddr;
    logic                 walk_re;
    logic                 edge_re;

    assign n_eff     = effective_nodes(node_count_reg);
    assign nmask     = node_mask(n_eff);
    assign unvisited = ~visited_reg & nmask;
    assign cand      = edge_rd_reg & ~visited_reg & nmask;
    assign enc_word  = (state_reg == ST_STEP) ? cand : unvisited;

    ssf_lowest_set u_lowest (
        .word  (enc_word),
        .index (enc_index),
        .found (enc_found)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign row_we      = in_xfer && (row_cnt_reg < COUNT_W'(MAX_NODES));
    assign walk_end    = !enc_found || (len_reg >= n_eff);
    assign search_done = (start_reg >= n_eff) || !enc_found;
    assign walk_pos    = COUNT_W'(start_reg + len_reg);

    always_comb
    begin
        walk_we    = 1'b0;
        walk_waddr = start_reg[NODE_W-1:0];
        edge_re    = 1'b0;
        unique case (state_reg)
            ST_NEW_WALK:
            begin
                walk_we = !search_done;
                edge_re = !search_done;
            end
            ST_STEP:
            begin
                walk_we    = !walk_end;
                edge_re    = !walk_end;
                walk_waddr = walk_pos[NODE_W-1:0];
            end
            default:
            begin
                walk_we = 1'b0;
            end
        endcase
    end

    assign walk_re    = (state_reg == ST_EMIT_READ);
    assign walk_raddr = NODE_W'(best_start_reg + emit_cnt_reg[NODE_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            edge_mem[row_cnt_reg[NODE_W-1:0]] <= in_data.row_bits;
        end
        if (edge_re)
        begin
            edge_rd_reg <= edge_mem[enc_index];
        end
        if (walk_we)
        begin
            walk_mem[walk_waddr] <= enc_index;
        end
        if (walk_re)
        begin
            walk_rd_reg <= walk_mem[walk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= COUNT_W'(32);
            row_cnt_reg    <= '0;
            visited_reg    <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            best_start_reg <= '0;
            best_len_reg   <= COUNT_W'(33);
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_full_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (row_we)
                        begin
                            row_cnt_reg <= COUNT_W'(row_cnt_reg + 1'b1);
                        end
                        if (in_data.last_row)
                        begin
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT:
                begin
                    visited_reg    <= '0;
                    start_reg      <= '0;
                    best_start_reg <= '0;
                    best_len_reg   <= COUNT_W'(n_eff + 1'b1);
                    row_cnt_reg    <= '0;
                    state_reg      <= ST_NEW_WALK;
                end
                ST_NEW_WALK:
                begin
                    if (search_done)
                    begin
                        emit_cnt_reg <= '0;
                        state_reg    <= ST_EMIT_READ;
                    end
                    else
                    begin
                        visited_reg[enc_index] <= 1'b1;
                        len_reg                <= COUNT_W'(1);
                        state_reg              <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (walk_end)
                    begin
                        // Strictly shorter only, so the first of equal cycles is kept.
                        if (len_reg < best_len_reg)
                        begin
                            best_len_reg   <= len_reg;
                            best_start_reg <= start_reg[NODE_W-1:0];
                        end
                        start_reg <= walk_pos;
                        state_reg <= ST_NEW_WALK;
                    end
                    else
                    begin
                        visited_reg[enc_index] <= 1'b1;
                        len_reg                <= COUNT_W'(len_reg + 1'b1);
                    end
                end
                ST_EMIT_READ:
                begin
                    out_full_reg  <= (best_len_reg == n_eff);
                    out_last_reg  <= (COUNT_W'(emit_cnt_reg + 1'b1) == best_len_reg);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_EMIT_HOLD;
                end
                ST_EMIT_HOLD:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        emit_cnt_reg  <= COUNT_W'(emit_cnt_reg + 1'b1);
                        state_reg     <= out_last_reg ? ST_IDLE : ST_EMIT_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid               = out_valid_reg;
    assign out_data.node_index     = walk_rd_reg;
    assign out_data.subtour_length = best_len_reg;
    assign out_data.full_tour      = out_full_reg;
    assign out_data.last           = out_last_reg;

endmodule
